// File: rtl/core/gfd_pkg.sv
`timescale 1ns / 1ps

package gfd_pkg;

  // Field and register widths
  localparam int SIZE_W    = 13;
  localparam int COORD_W   = 12;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_AXES  = 3;

  // Parameter defaults
  localparam int MAX_POINTS_DEF = 4096;
  localparam int AXES_DEF       = 3;

  localparam logic [SIZE_W-1:0] SIZE_RST = 13'd16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  // Request function and response status codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Microcode
  localparam int PC_W = 5;

  typedef enum logic [1:0] {
    MUL_SXSY,
    MUL_TOTAL,
    MUL_YOFF,
    MUL_ZOFF
  } mul_sel_t;

  typedef enum logic [2:0] {
    OFF_M2,
    OFF_M1,
    OFF_C,
    OFF_P1,
    OFF_P2
  } rd_off_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_CLR,
    TERM_CLR,
    TERM_ADD1,
    TERM_SUB4,
    TERM_ADD6,
    ACC_FOLD
  } acc_op_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_QUERY,
    RES_WRITE,
    RES_ERR
  } res_op_t;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_BAD,
    JMP_WRITE,
    JMP_NOTERM,
    JMP_MORE
  } jmp_t;

  typedef struct packed {
    logic            mul_en;
    mul_sel_t        mul_sel;
    logic            addr_ld;
    logic            rd_en;
    rd_off_t         rd_off;
    acc_op_t         acc_op;
    logic            wr_en;
    res_op_t         res_op;
    logic            ax_clr;
    logic            ax_inc;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic bad;
    logic is_write;
    logic no_term;
    logic more_ax;
  } cond_t;

  localparam ucode_t UCODE_NOP = '0;

  // Jump targets
  localparam logic [PC_W-1:0] ST_AXIS  = 5'd7;
  localparam logic [PC_W-1:0] ST_NEXT  = 5'd15;
  localparam logic [PC_W-1:0] ST_WRITE = 5'd17;
  localparam logic [PC_W-1:0] ST_ERR   = 5'd18;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = UCODE_NOP;
    unique case (pc)
      5'd0: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_SXSY;
        w.acc_op  = ACC_CLR;
        w.ax_clr  = 1'b1;
      end
      5'd1: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_TOTAL;
      end
      5'd2: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_YOFF;
      end
      5'd3: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_ZOFF;
      end
      5'd4: w.addr_ld = 1'b1;
      5'd5: begin
        w.jmp    = JMP_BAD;
        w.target = ST_ERR;
      end
      5'd6: begin
        w.jmp    = JMP_WRITE;
        w.target = ST_WRITE;
      end
      5'd7: begin
        w.jmp    = JMP_NOTERM;
        w.target = ST_NEXT;
      end
      5'd8: begin
        w.rd_en  = 1'b1;
        w.rd_off = OFF_M2;
        w.acc_op = TERM_CLR;
      end
      5'd9: begin
        w.rd_en  = 1'b1;
        w.rd_off = OFF_M1;
        w.acc_op = TERM_ADD1;
      end
      5'd10: begin
        w.rd_en  = 1'b1;
        w.rd_off = OFF_C;
        w.acc_op = TERM_SUB4;
      end
      5'd11: begin
        w.rd_en  = 1'b1;
        w.rd_off = OFF_P1;
        w.acc_op = TERM_ADD6;
      end
      5'd12: begin
        w.rd_en  = 1'b1;
        w.rd_off = OFF_P2;
        w.acc_op = TERM_SUB4;
      end
      5'd13: w.acc_op = TERM_ADD1;
      5'd14: w.acc_op = ACC_FOLD;
      5'd15: begin
        w.ax_inc = 1'b1;
        w.jmp    = JMP_MORE;
        w.target = ST_AXIS;
      end
      5'd16: w.res_op = RES_QUERY;
      5'd17: begin
        w.wr_en  = 1'b1;
        w.res_op = RES_WRITE;
      end
      5'd18: w.res_op = RES_ERR;
      default: ;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/gfd_req_if.sv
`timescale 1ns / 1ps

interface gfd_req_if import gfd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COORD_W-1:0] coord_z;
  logic signed [DATA_W-1:0] sample;

  modport source(output valid, func, coord_x, coord_y, coord_z, sample, input ready);
  modport sink(input valid, func, coord_x, coord_y, coord_z, sample, output ready);
endinterface

// File: rtl/core/gfd_rsp_if.sv
`timescale 1ns / 1ps

interface gfd_rsp_if import gfd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] dissipation;
  logic                     status;

  modport source(output valid, dissipation, status, input ready);
  modport sink(input valid, dissipation, status, output ready);
endinterface

// File: rtl/core/gfd_ram.sv
`timescale 1ns / 1ps

module gfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/core/gfd_seq.sv
`timescale 1ns / 1ps

module gfd_seq import gfd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  logic   out_free,
  input  cond_t  cond,
  output logic   busy,
  output ucode_t cw
);

  logic [PC_W-1:0] pc;
  ucode_t          word;
  logic            take;

  assign word = ucode_rom(pc);
  assign cw   = busy ? word : UCODE_NOP;

  always_comb begin
    unique case (word.jmp)
      JMP_NONE:   take = 1'b0;
      JMP_BAD:    take = cond.bad;
      JMP_WRITE:  take = cond.is_write;
      JMP_NOTERM: take = cond.no_term;
      JMP_MORE:   take = cond.more_ax;
      default:    take = 1'b0;
    endcase
  end

  // Result steps end the program; hold there until the output slot frees
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        pc   <= '0;
      end
    end else if (word.res_op != RES_NONE) begin
      if (out_free) begin
        busy <= 1'b0;
        pc   <= '0;
      end
    end else if (take) begin
      pc <= word.target;
    end else begin
      pc <= pc + 1'b1;
    end
  end

endmodule

// File: rtl/core/grid_fourth_difference_dissipation.sv
`timescale 1ns / 1ps

// Fourth-difference dissipation on a grid of up to three axes, Q16.16.
//
// Channels: req (sink) carries func, coord_x/y/z and sample; rsp (source)
// carries dissipation and status. Both use valid/ready; a request or result
// moves at a rising edge with valid and ready high. The cfg port writes the
// size registers (index 0 = x, 1 = y, 2 = z) whenever cfg_we is high.
//
// One request is in flight at a time; req.ready is high while the sequencer
// is free. The microcode program makes four passes through a shared
// multiplier to form the grid size and address; an error or a sample write
// then goes straight to its result step, while a query makes five reads of
// the single-port field memory for each axis with a term.
//
// A finished result waits in the output register; a new request is taken
// meanwhile and runs until its own result step, where it holds while the
// receiver stalls. Reset clears the sequencer and the response valid and
// sets all sizes to 16; the field memory is not cleared.

module grid_fourth_difference_dissipation import gfd_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int AXES       = AXES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  gfd_req_if.sink              req,
  gfd_rsp_if.source            rsp
);

  localparam int AW      = $clog2(MAX_POINTS);
  localparam int SXSY_W  = 2 * SIZE_W;
  localparam int TOTAL_W = 3 * SIZE_W;
  localparam int TERM_W  = DATA_W + 4;
  localparam logic [TOTAL_W-1:0] MAX_TOTAL = TOTAL_W'(MAX_POINTS);
  localparam logic [1:0]         LAST_AX   = 2'(AXES - 1);
  localparam logic signed [TERM_W-1:0] SAT_HI = TERM_W'(64'sh7FFF_FFFF);
  localparam logic signed [TERM_W-1:0] SAT_LO = -TERM_W'(64'sh8000_0000);

  // Configuration
  logic [SIZE_W-1:0] size_reg [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg[0] <= SIZE_RST;
      size_reg[1] <= SIZE_RST;
      size_reg[2] <= SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE_X: size_reg[0] <= cfg_data;
        CFG_SIZE_Y: size_reg[1] <= cfg_data;
        CFG_SIZE_Z: size_reg[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Axes at or above AXES have a size of one
  logic [SIZE_W-1:0] sz_eff [NUM_AXES];

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      sz_eff[k] = (k < AXES) ? size_reg[k] : SIZE_W'(1);
    end
  end

  // Request capture
  logic                busy;
  logic                start;
  logic                func_q;
  logic [COORD_W-1:0]  co [NUM_AXES];
  logic [DATA_W-1:0]   sample_q;

  assign req.ready = !busy;
  assign start     = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (start) begin
      func_q   <= req.func;
      co[0]    <= req.coord_x;
      co[1]    <= req.coord_y;
      co[2]    <= req.coord_z;
      sample_q <= req.sample;
    end
  end

  // Sequencer
  ucode_t cw;
  cond_t  cond;
  logic   out_free;

  gfd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .cond     (cond),
    .busy     (busy),
    .cw       (cw)
  );

  // Shared multiplier: grid size, then the address offsets
  logic [SXSY_W-1:0]  mul_a;
  logic [SIZE_W-1:0]  mul_b;
  logic [TOTAL_W-1:0] prod;
  logic [SXSY_W-1:0]  sxsy;
  logic [TOTAL_W-1:0] total;
  logic [AW-1:0]      yoff;
  logic [AW-1:0]      zoff;

  always_comb begin
    unique case (cw.mul_sel)
      MUL_SXSY: begin
        mul_a = SXSY_W'(sz_eff[0]);
        mul_b = sz_eff[1];
      end
      MUL_TOTAL: begin
        mul_a = sxsy;
        mul_b = sz_eff[2];
      end
      MUL_YOFF: begin
        mul_a = SXSY_W'(sz_eff[0]);
        mul_b = SIZE_W'(co[1]);
      end
      MUL_ZOFF: begin
        mul_a = sxsy;
        mul_b = SIZE_W'(co[2]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = TOTAL_W'(mul_a) * TOTAL_W'(mul_b);

  always_ff @(posedge clk) begin
    if (cw.mul_en) begin
      unique case (cw.mul_sel)
        MUL_SXSY:  sxsy  <= prod[SXSY_W-1:0];
        MUL_TOTAL: total <= prod;
        MUL_YOFF:  yoff  <= prod[AW-1:0];
        MUL_ZOFF:  zoff  <= prod[AW-1:0];
        default: ;
      endcase
    end
  end

  // Address and error check
  logic          coord_bad;
  logic [AW-1:0] addr;
  logic          bad;

  always_comb begin
    coord_bad = 1'b0;
    for (int k = 0; k < NUM_AXES; k++) begin
      if (SIZE_W'(co[k]) >= sz_eff[k]) begin
        coord_bad = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cw.addr_ld) begin
      addr <= AW'(co[0]) + yoff + zoff;
      bad  <= coord_bad || (total > MAX_TOTAL);
    end
  end

  // Axis walk: stride and whether this axis adds a term
  logic [1:0]        ax;
  logic [AW-1:0]     stride;
  logic [SIZE_W-1:0] ax_n;
  logic [COORD_W-1:0] ax_c;

  always_ff @(posedge clk) begin
    if (cw.ax_clr) begin
      ax <= '0;
    end else if (cw.ax_inc) begin
      ax <= ax + 1'b1;
    end
  end

  always_comb begin
    unique case (ax)
      2'd0: begin
        stride = AW'(1);
        ax_n   = sz_eff[0];
        ax_c   = co[0];
      end
      2'd1: begin
        stride = AW'(sz_eff[0]);
        ax_n   = sz_eff[1];
        ax_c   = co[1];
      end
      2'd2: begin
        stride = AW'(sxsy);
        ax_n   = sz_eff[2];
        ax_c   = co[2];
      end
      default: begin
        stride = '0;
        ax_n   = '0;
        ax_c   = '0;
      end
    endcase
  end

  assign cond.bad      = bad;
  assign cond.is_write = (func_q == FUNC_WRITE);
  assign cond.no_term  = (ax_n <= SIZE_W'(4)) || (ax_c < COORD_W'(2))
                         || ((SIZE_W'(ax_c) + SIZE_W'(3)) > ax_n);
  assign cond.more_ax  = (ax < LAST_AX);

  // Field memory; neighbor addresses stay inside the grid whenever read
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     ram_addr;
  logic [DATA_W-1:0] rd_data;

  always_comb begin
    unique case (cw.rd_off)
      OFF_M2:  rd_addr = addr - (stride << 1);
      OFF_M1:  rd_addr = addr - stride;
      OFF_C:   rd_addr = addr;
      OFF_P1:  rd_addr = addr + stride;
      OFF_P2:  rd_addr = addr + (stride << 1);
      default: rd_addr = addr;
    endcase
  end

  assign ram_addr = cw.rd_en ? rd_addr : addr;

  gfd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_POINTS)
  ) u_field (
    .clk   (clk),
    .we    (cw.wr_en),
    .addr  (ram_addr),
    .wdata (sample_q),
    .rdata (rd_data)
  );

  // Stencil accumulate: read data arrives in the step after its address
  logic signed [TERM_W-1:0] q;
  logic signed [TERM_W-1:0] term;
  logic signed [TERM_W-1:0] acc;
  logic signed [TERM_W-1:0] acc_sat;

  assign q = TERM_W'(signed'(rd_data));

  always_ff @(posedge clk) begin
    unique case (cw.acc_op)
      ACC_NONE:  ;
      ACC_CLR:   acc  <= '0;
      TERM_CLR:  term <= '0;
      TERM_ADD1: term <= term + q;
      TERM_SUB4: term <= term - (q <<< 2);
      TERM_ADD6: term <= term + (q <<< 2) + (q <<< 1);
      ACC_FOLD:  acc  <= acc + (term >>> 4);
      default: ;
    endcase
  end

  always_comb begin
    if (acc > SAT_HI) begin
      acc_sat = SAT_HI;
    end else if (acc < SAT_LO) begin
      acc_sat = SAT_LO;
    end else begin
      acc_sat = acc;
    end
  end

  // Output register
  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((cw.res_op != RES_NONE) && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cw.res_op != RES_NONE) && out_free) begin
      unique case (cw.res_op)
        RES_QUERY: begin
          rsp.dissipation <= acc_sat[DATA_W-1:0];
          rsp.status      <= STATUS_OK;
        end
        RES_WRITE: begin
          rsp.dissipation <= '0;
          rsp.status      <= STATUS_OK;
        end
        RES_ERR: begin
          rsp.dissipation <= '0;
          rsp.status      <= STATUS_ERR;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

// Testbench for the fourth-difference dissipation block.
//
// A request either stores a Q16.16 sample at a grid point or asks for the
// dissipation at a point. The bench keeps its own copy of the grid sizes and
// of the field memory, works out the expected result for every request at
// the edge where it is taken, and checks every result against the oldest
// expectation still waiting.
//
// The memory in the block is not cleared by reset. Before any query, write
// every neighbor that the query will read, so no query ever touches a word
// that was never written.
module tb;
  import gfd_pkg::*;

  localparam int RESET_CYCLES   = 6;
  // Worst quiet stretch: a query with a term on each axis, the longest result
  // stall and the longest request gap. Allow many times that.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int TOTAL_ITEMS    = 850;
  // The last requests run with no idling on either side.
  localparam int CALM_ITEMS     = 100;
  localparam int GRID_POINTS    = MAX_POINTS_DEF;
  localparam int REPORT_LIMIT   = 10;

  // No register answers to this index; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  // Index 0 is the fastest axis (x), index 2 the slowest (z).
  typedef logic [NUM_AXES-1:0][COORD_W-1:0] coord_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] dissipation;
    logic                     status;
  } result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  gfd_req_if req_ch ();
  gfd_rsp_if rsp_ch ();

  grid_fourth_difference_dissipation i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Shadow of the block: grid sizes, field memory and which words hold data.
  logic [SIZE_W-1:0] grid_size [NUM_AXES];
  logic [DATA_W-1:0] field_mem [GRID_POINTS];
  bit                written   [GRID_POINTS];

  // Expected results, oldest first.
  result_t pending_results [$];

  bit idle_en = 1'b1;
  int mismatches;
  int items_sent;
  int queries_sent;
  int error_answers;
  int limit_answers;
  int shapes_run;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Axes beyond the configured axis count behave as length one.
  function automatic longint axis_len(int a);
    return (a >= AXES_DEF) ? 64'sd1 : longint'(grid_size[a]);
  endfunction

  function automatic longint axis_stride(int a);
    longint s;
    int     b;
    s = 1;
    for (b = 0; b < a; b++) s *= axis_len(b);
    return s;
  endfunction

  // True when the grid is larger than the memory or the point lies outside it.
  function automatic bit grid_bad(coord_t c);
    longint total;
    bit     bad;
    int     a;
    total = 1;
    bad   = 1'b0;
    for (a = 0; a < NUM_AXES; a++) begin
      total *= axis_len(a);
      if (longint'(c[a]) >= axis_len(a)) bad = 1'b1;
    end
    return bad || (total > GRID_POINTS);
  endfunction

  function automatic longint point_addr(coord_t c);
    longint addr;
    int     a;
    addr = 0;
    for (a = 0; a < NUM_AXES; a++) addr += longint'(c[a]) * axis_stride(a);
    return addr;
  endfunction

  // An axis adds a term only when it is longer than four points and the point
  // sits at least two points away from both of its ends.
  function automatic bit has_term(coord_t c, int a);
    longint n;
    n = axis_len(a);
    return (n > 4) && (c[a] >= 2) && (longint'(c[a]) + 3 <= n);
  endfunction

  function automatic longint stored(longint addr);
    return longint'($signed(field_mem[addr]));
  endfunction

  // Work out the result of one request and apply a store to the shadow memory.
  function automatic result_t predict_result(logic func, coord_t c,
                                             logic signed [DATA_W-1:0] sample);
    result_t r;
    longint  addr;
    longint  d;
    longint  s;
    longint  acc;
    int      a;
    r = '0;
    if (grid_bad(c)) begin
      r.status = STATUS_ERR;
      return r;
    end
    r.status = STATUS_OK;
    addr = point_addr(c);
    if (func == FUNC_WRITE) begin
      field_mem[addr] = sample;
      written[addr]   = 1'b1;
      return r;
    end
    acc = 0;
    for (a = 0; a < NUM_AXES; a++) begin
      if (has_term(c, a)) begin
        d = axis_stride(a);
        s = stored(addr - 2 * d) - 4 * stored(addr - d) + 6 * stored(addr)
            - 4 * stored(addr + d) + stored(addr + 2 * d);
        // Divide by 16, rounding toward minus infinity.
        acc += s >>> 4;
      end
    end
    if (acc > longint'(Q_MAX)) acc = longint'(Q_MAX);
    else if (acc < longint'(Q_MIN)) acc = longint'(Q_MIN);
    r.dissipation = acc[DATA_W-1:0];
    return r;
  endfunction

  // Mostly random words, with the extremes and the small values mixed in.
  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Pick a position on one axis, inside the grid where the axis allows it.
  function automatic logic [COORD_W-1:0] pick_coord(int a, bit interior);
    longint n;
    longint lim;
    n = axis_len(a);
    if (n == 0) return COORD_W'($urandom);
    lim = (n > GRID_POINTS) ? GRID_POINTS : n;
    if (interior && lim > 4) return COORD_W'($urandom_range(2, lim - 3));
    return COORD_W'($urandom_range(0, lim - 1));
  endfunction

  function automatic coord_t pick_point(bit interior);
    coord_t c;
    int     a;
    for (a = 0; a < NUM_AXES; a++) c[a] = pick_coord(a, interior);
    return c;
  endfunction

  // Send one request and record its expected result once it is taken.
  // Leave valid high on return so a following request can go out with no gap.
  task automatic send_request(logic func, coord_t c, logic signed [DATA_W-1:0] sample);
    result_t want;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.func    <= func;
    req_ch.coord_x <= c[0];
    req_ch.coord_y <= c[1];
    req_ch.coord_z <= c[2];
    req_ch.sample  <= sample;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    want = predict_result(func, c, sample);
    pending_results = {pending_results, want};
    items_sent++;
    if (func == FUNC_QUERY) queries_sent++;
    if (want.status == STATUS_ERR) error_answers++;
    else if (func == FUNC_QUERY && (want.dissipation == Q_MAX ||
                                    want.dissipation == Q_MIN))
      limit_answers++;
  endtask

  // Query a point, first writing every neighbor it reads that holds no data.
  task automatic send_query(coord_t c, logic signed [DATA_W-1:0] sample);
    coord_t nb;
    longint base;
    longint d;
    int     a;
    int     k;
    if (!grid_bad(c)) begin
      base = point_addr(c);
      for (a = 0; a < NUM_AXES; a++) begin
        if (has_term(c, a)) begin
          d = axis_stride(a);
          for (k = -2; k <= 2; k++) begin
            if (!written[base + k * d]) begin
              nb    = c;
              nb[a] = c[a] + k;
              send_request(FUNC_WRITE, nb, pick_sample());
            end
          end
        end
      end
    end
    send_request(FUNC_QUERY, c, sample);
  endtask

  // Drop valid and hold until every result is in; the block is idle after.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic configure_grid(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
                                logic [SIZE_W-1:0] sz);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SIZE_X;
    cfg_data  <= sx;
    @(posedge clk);
    cfg_index <= CFG_SIZE_Y;
    cfg_data  <= sy;
    @(posedge clk);
    cfg_index <= CFG_SIZE_Z;
    cfg_data  <= sz;
    @(posedge clk);
    cfg_we <= 1'b0;
    grid_size[0] = sx;
    grid_size[1] = sy;
    grid_size[2] = sz;
    shapes_run++;
  endtask

  // Sizes straight out of reset (16 on every axis): a corner store, a query at
  // the upper corner where no axis gives a term, and a point just past x.
  task automatic test_reset_grid();
    coord_t c;
    c = {NUM_AXES{12'd15}};
    send_request(FUNC_WRITE, c, Q_MIN);
    send_query(c, $urandom);
    c    = '0;
    c[0] = 12'd16;
    send_query(c, $urandom);
  endtask

  // Drive both axes of a 5x5 grid to their largest term so that the sum runs
  // past the top of the range, then the mirror pattern past the bottom.
  task automatic test_saturation();
    coord_t                   mid;
    coord_t                   arm;
    logic signed [DATA_W-1:0] up;
    logic signed [DATA_W-1:0] down;
    int                       sweep;
    int                       a;
    int                       k;
    configure_grid(13'd5, 13'd5, 13'd1);
    mid    = '0;
    mid[0] = 12'd2;
    mid[1] = 12'd2;
    for (sweep = 0; sweep < 2; sweep++) begin
      // Points with a positive weight get one extreme, the -4 points the other.
      up   = (sweep == 0) ? Q_MAX : Q_MIN;
      down = (sweep == 0) ? Q_MIN : Q_MAX;
      send_request(FUNC_WRITE, mid, up);
      for (a = 0; a < 2; a++) begin
        for (k = -2; k <= 2; k++) begin
          if (k != 0) begin
            arm    = mid;
            arm[a] = mid[a] + k;
            send_request(FUNC_WRITE, arm, (k == 1 || k == -1) ? down : up);
          end
        end
      end
      send_query(mid, $urandom);
    end
  endtask

  // One axis of 4096 points: reach the top coordinate on every bit.
  task automatic test_long_axis();
    coord_t c;
    configure_grid(13'd4096, 13'd1, 13'd1);
    c    = '0;
    c[0] = 12'd4095;
    send_request(FUNC_WRITE, c, Q_MAX);
    send_query(c, '1);
  endtask

  // Grids the block must refuse: larger than the memory, an axis of zero
  // points, and every size register at its top value.
  task automatic test_bad_grids();
    coord_t c;
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_UNUSED;
    cfg_data  <= '1;
    @(posedge clk);
    cfg_we <= 1'b0;
    configure_grid(13'd4096, 13'd2, 13'd1);
    c    = '0;
    c[0] = 12'd1;
    c[1] = 12'd1;
    send_request(FUNC_WRITE, c, $urandom);
    configure_grid(13'd0, 13'd16, 13'd16);
    send_query('0, $urandom);
    configure_grid(13'h1fff, 13'h1fff, 13'h1fff);
    send_query(pick_point(1'b0), $urandom);
  endtask

  // Random grid shapes, each with a burst of requests, until the count of
  // requests sent reaches the target. Most requests are queries, three in four
  // of them at points well inside the grid; the rest are stores and noise near or past the edge.
  task automatic test_random_grids(int target);
    logic [SIZE_W-1:0] sx;
    logic [SIZE_W-1:0] sy;
    logic [SIZE_W-1:0] sz;
    coord_t            c;
    int                len;
    int                n;
    int                r;
    int                a;
    while (items_sent < target) begin
      sx = SIZE_W'($urandom_range(1, 12));
      sy = SIZE_W'($urandom_range(1, 12));
      sz = SIZE_W'($urandom_range(1, 10));
      case ($urandom_range(0, 9))
        0: begin
          r  = $urandom_range(0, 2);
          sx = (r == 0) ? 13'd4096 : 13'd1;
          sy = (r == 1) ? 13'd4096 : 13'd1;
          sz = (r == 2) ? 13'd4096 : 13'd1;
        end
        1: begin
          r  = $urandom_range(0, 2);
          sx = (r == 2) ? 13'd1 : ((r == 1) ? 13'd16 : 13'd64);
          sy = (r == 1) ? 13'd16 : 13'd64;
          sz = (r == 0) ? 13'd1 : ((r == 1) ? 13'd16 : 13'd64);
        end
        2: begin
          case ($urandom_range(0, 2))
            0: sx = 13'd0;
            1: begin
              sx = 13'd65;
              sy = 13'd64;
              sz = 13'd1;
            end
            default: sz = 13'h1fff;
          endcase
        end
        default: ;
      endcase
      configure_grid(sx, sy, sz);
      len = grid_bad('0) ? $urandom_range(4, 10) : $urandom_range(30, 70);
      for (n = 0; n < len && items_sent < target; n++) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          send_query(pick_point($urandom_range(0, 3) != 0), $urandom);
        end else if (r < 85) begin
          send_request(FUNC_WRITE, pick_point(1'b0), pick_sample());
        end else begin
          // Push one axis just past its end, or anywhere at all.
          c    = pick_point(1'b0);
          a    = $urandom_range(0, NUM_AXES - 1);
          c[a] = $urandom_range(0, 1) ? grid_size[a][COORD_W-1:0] : COORD_W'($urandom);
          if ($urandom_range(0, 1)) send_request(FUNC_WRITE, c, pick_sample());
          else send_query(c, $urandom);
        end
      end
    end
  endtask

  // Result side: hold ready low in short random bursts while idling is on.
  initial begin : result_stall
    int hold;
    hold         = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0 && idle_en && $urandom_range(0, 3) == 0) hold = $urandom_range(1, 3);
      if (hold > 0) begin
        rsp_ch.ready <= 1'b0;
        hold--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic note_mismatch(string what, logic signed [DATA_W-1:0] want,
                               logic signed [DATA_W-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch in %s: expected %0d, got %0d", what, want, got);
  endtask

  // Compare each result taken with the oldest expectation.
  initial begin : result_check
    result_t want;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected result", '0, rsp_ch.dissipation);
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.status !== want.status)
            note_mismatch("status", want.status, rsp_ch.status);
          if (rsp_ch.dissipation !== want.dissipation)
            note_mismatch("dissipation", want.dissipation, rsp_ch.dissipation);
        end
      end
    end
  end

  // End the run when neither a request nor a result has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("no request or result moved for %0d cycles", quiet);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int a;
    req_ch.valid   = 1'b0;
    req_ch.func    = FUNC_WRITE;
    req_ch.coord_x = '0;
    req_ch.coord_y = '0;
    req_ch.coord_z = '0;
    req_ch.sample  = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_SIZE_X;
    cfg_data       = SIZE_RST;
    for (a = 0; a < NUM_AXES; a++) grid_size[a] = SIZE_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_grid();
    test_saturation();
    test_long_axis();
    test_bad_grids();
    test_random_grids(TOTAL_ITEMS - CALM_ITEMS);
    idle_en = 1'b0;
    test_random_grids(TOTAL_ITEMS);

    // Drain, then leave room for any stray result.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d queries) over %0d grid shapes.",
             items_sent, queries_sent, shapes_run);
    $display("Seen %0d error answers and %0d queries at the Q16.16 limits; %0d mismatches.",
             error_answers, limit_answers, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: grid_fourth_difference_dissipation.f
rtl/core/gfd_pkg.sv
rtl/core/gfd_req_if.sv
rtl/core/gfd_rsp_if.sv
rtl/core/gfd_ram.sv
rtl/core/gfd_seq.sv
rtl/core/grid_fourth_difference_dissipation.sv
test/tb.sv
